FILE: sv/hvt_pkg.sv
// Shared types and constants of the hashed vote tally.
`timescale 1ns / 1ps

package hvt_pkg;

	// Golden-ratio fraction in 0.32 fixed point
	localparam logic [31:0] GOLDEN_FRAC = 32'h9E37_79B9;
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam int KEY_W = 64;
	localparam int IN_DATA_W = 256;
	localparam int OUT_DATA_W = 144;
	localparam int CFG_DATA_W = 11;

	// Configuration register indexes
	localparam logic REG_VOTER_SLOTS = 1'b0;
	localparam logic REG_CAND_SLOTS = 1'b1;

	typedef enum logic [1:0] {
		K_ADD_VOTER = 2'd0,
		K_ADD_CAND  = 2'd1,
		K_VOTE      = 2'd2,
		K_REPORT    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_FULL          = 3'd1,
		ST_VOTER_UNKNOWN = 3'd2,
		ST_ALREADY_VOTED = 3'd3,
		ST_CAND_UNKNOWN  = 3'd4
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    load_in;
		logic    hash_a;
		logic    hash_b;
		logic    step;
		logic    tsel;
		logic    use_choice;
		logic    ins_wr;
		logic    vote_wr;
		logic    vslot_ld;
		logic    scan_rd;
		logic    scan_cmp;
		logic    clr;
		logic    res_load;
		status_t status;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		kind_t kind;
		logic  used;
		logic  match;
		logic  last;
		logic  voted;
		logic  out_free;
		logic  scan_last;
		logic  clr_last;
	} sts_t;

endpackage

FILE: sv/hvt_datapath.sv
// Datapath: input and config registers, hash and probe unit, tables, scan and result register.
`timescale 1ns / 1ps

module hvt_datapath #(
	parameter int VOTER_SLOTS = 1024,
	parameter int CANDIDATE_SLOTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [hvt_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [hvt_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [hvt_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  hvt_pkg::cmd_t                       cmd,
	output hvt_pkg::sts_t                       sts
);

	localparam int VAW = $clog2(VOTER_SLOTS);
	localparam int CAW = $clog2(CANDIDATE_SLOTS);
	localparam int MAXS = (VOTER_SLOTS > CANDIDATE_SLOTS) ? VOTER_SLOTS : CANDIDATE_SLOTS;
	localparam int MW = $clog2(MAXS + 1);
	localparam int CLW = $clog2(MAXS);
	localparam int KW = hvt_pkg::KEY_W;
	localparam int CW = hvt_pkg::COUNT_W;

	// Configuration registers
	logic [10:0] vsu_q;
	logic [6:0]  csu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsu_q <= 11'd1024;
			csu_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hvt_pkg::REG_VOTER_SLOTS: vsu_q <= cfg_data;
				hvt_pkg::REG_CAND_SLOTS:  csu_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Clamp slot counts to 1 .. table depth
	logic [MW-1:0] mv, mc, m;
	always_comb begin
		if (vsu_q == '0) mv = MW'(1);
		else if (32'(vsu_q) > 32'(VOTER_SLOTS)) mv = MW'(VOTER_SLOTS);
		else mv = MW'(vsu_q);
		if (csu_q == '0) mc = MW'(1);
		else if (32'(csu_q) > 32'(CANDIDATE_SLOTS)) mc = MW'(CANDIDATE_SLOTS);
		else mc = MW'(csu_q);
	end
	assign m = cmd.tsel ? mc : mv;

	// Hold the accepted item
	hvt_pkg::kind_t kind_q;
	logic [KW-1:0] kv_q, kn_q, cv_q, cn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= hvt_pkg::K_ADD_VOTER;
		end else if (cmd.load_in) begin
			kind_q <= hvt_pkg::kind_t'(s_tuser);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kv_q <= s_tdata[KW-1:0];
			kn_q <= s_tdata[2*KW-1:KW];
			cv_q <= s_tdata[3*KW-1:2*KW];
			cn_q <= s_tdata[4*KW-1:3*KW];
		end
	end

	logic [KW-1:0] hv, hn;
	assign hv = cmd.use_choice ? cv_q : kv_q;
	assign hn = cmd.use_choice ? cn_q : kn_q;

	// Hash: fraction, then scale to slot count
	logic [31:0] frac_d, frac_q;
	logic [31+MW:0] hprod;
	logic [MW-1:0] home;
	assign frac_d = hv[31:0] * hvt_pkg::GOLDEN_FRAC;
	assign hprod = (32 + MW)'(frac_q) * (32 + MW)'(m);
	assign home = hprod[31+MW:32];

	// Quadratic probe: p tracks home + i(i+1)/2 mod m, odd probes sit one below
	logic [MW-1:0] p_q, i_q, paddr, pnext;
	logic [MW:0] psum;
	assign paddr = (i_q[0] && p_q == '0) ? m - MW'(1) : p_q - MW'(i_q[0]);
	assign psum = {1'b0, p_q} + {1'b0, i_q} + (MW + 1)'(1);
	assign pnext = (psum >= {1'b0, m}) ? MW'(psum - {1'b0, m}) : MW'(psum);

	always_ff @(posedge clk) begin
		if (cmd.hash_a) frac_q <= frac_d;
		if (cmd.hash_b) begin
			p_q <= home;
			i_q <= '0;
		end else if (cmd.step) begin
			p_q <= pnext;
			i_q <= i_q + MW'(1);
		end
	end

	// Clearing sweep and scan counters
	logic [CLW-1:0] clr_q;
	logic [CAW-1:0] scan_q;
	logic scan_last;
	assign scan_last = scan_q == CAW'(CANDIDATE_SLOTS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			scan_q <= '0;
		end else begin
			if (cmd.clr) clr_q <= (clr_q == CLW'(MAXS - 1)) ? '0 : clr_q + CLW'(1);
			if (cmd.scan_cmp) scan_q <= scan_last ? '0 : scan_q + CAW'(1);
		end
	end

	// Voter table: key store and flags {voted, used}
	logic [2*KW-1:0] vkey_mem [VOTER_SLOTS];
	logic [1:0]      vflag_mem [VOTER_SLOTS];
	logic [2*KW-1:0] vkey_rd;
	logic [1:0]      vflag_rd;
	logic [VAW-1:0]  vslot_q, vf_addr;
	logic [1:0]      vf_data;
	logic            vf_we, vk_we;

	always_comb begin
		vf_we = 1'b0;
		vf_addr = paddr[VAW-1:0];
		vf_data = 2'b01;
		vk_we = cmd.ins_wr && !cmd.tsel;
		if (cmd.clr) begin
			vf_we = 32'(clr_q) < 32'(VOTER_SLOTS);
			vf_addr = clr_q[VAW-1:0];
			vf_data = 2'b00;
		end else if (cmd.vote_wr) begin
			vf_we = 1'b1;
			vf_addr = vslot_q;
			vf_data = 2'b11;
		end else if (vk_we) begin
			vf_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		vkey_rd <= vkey_mem[paddr[VAW-1:0]];
		vflag_rd <= vflag_mem[paddr[VAW-1:0]];
		if (vk_we) vkey_mem[paddr[VAW-1:0]] <= {hn, hv};
		if (vf_we) vflag_mem[vf_addr] <= vf_data;
		if (cmd.vslot_ld) vslot_q <= paddr[VAW-1:0];
	end

	// Candidate table: key store and {count, used}
	logic [2*KW-1:0] ckey_mem [CANDIDATE_SLOTS];
	logic [CW:0]     cflag_mem [CANDIDATE_SLOTS];
	logic [2*KW-1:0] ckey_rd;
	logic [CW:0]     cflag_rd;
	logic [CAW-1:0]  c_ra, cf_addr;
	logic [CW:0]     cf_data;
	logic [CW-1:0]   cinc;
	logic            cf_we, ck_we;

	assign c_ra = cmd.scan_rd ? scan_q : paddr[CAW-1:0];
	assign cinc = (cflag_rd[CW:1] == hvt_pkg::COUNT_MAX) ? cflag_rd[CW:1]
		: cflag_rd[CW:1] + CW'(1);

	always_comb begin
		cf_we = 1'b0;
		cf_addr = paddr[CAW-1:0];
		cf_data = {{CW{1'b0}}, 1'b1};
		ck_we = cmd.ins_wr && cmd.tsel;
		if (cmd.clr) begin
			cf_we = 32'(clr_q) < 32'(CANDIDATE_SLOTS);
			cf_addr = clr_q[CAW-1:0];
			cf_data = '0;
		end else if (cmd.vote_wr) begin
			cf_we = 1'b1;
			cf_data = {cinc, 1'b1};
		end else if (ck_we) begin
			cf_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		ckey_rd <= ckey_mem[c_ra];
		cflag_rd <= cflag_mem[c_ra];
		if (ck_we) ckey_mem[paddr[CAW-1:0]] <= {hn, hv};
		if (cf_we) cflag_mem[cf_addr] <= cf_data;
	end

	// Track the leading candidate during the report scan
	logic [CW-1:0] best_q;
	logic [KW-1:0] wv_q, wn_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			best_q <= '0;
			wv_q <= '0;
			wn_q <= '0;
		end else if (cmd.scan_cmp && cflag_rd[0] && cflag_rd[CW:1] > best_q) begin
			best_q <= cflag_rd[CW:1];
			wv_q <= ckey_rd[KW-1:0];
			wn_q <= ckey_rd[2*KW-1:KW];
		end
	end

	// Result register
	logic m_tvalid_q;
	logic [hvt_pkg::OUT_DATA_W-1:0] out_q;
	logic report;
	assign report = kind_q == hvt_pkg::K_REPORT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_q <= {2'b00,
				report ? best_q : {CW{1'b0}},
				report ? wn_q : {KW{1'b0}},
				report ? wv_q : {KW{1'b0}},
				cmd.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = out_q;

	// Status to the controller
	logic vmatch, cmatch;
	assign vmatch = vflag_rd[0] && vkey_rd == {hn, hv};
	assign cmatch = cflag_rd[0] && ckey_rd == {hn, hv};

	always_comb begin
		sts.kind = kind_q;
		sts.used = cmd.tsel ? cflag_rd[0] : vflag_rd[0];
		sts.match = cmd.tsel ? cmatch : vmatch;
		sts.last = i_q == m - MW'(1);
		sts.voted = vflag_rd[1];
		sts.out_free = !m_tvalid_q || m_tready;
		sts.scan_last = scan_last;
		sts.clr_last = clr_q == CLW'(MAXS - 1);
	end

endmodule

FILE: sv/hvt_ctrl.sv
// Controller: sequences hashing, probing, the report scan, table clearing and the result.
`timescale 1ns / 1ps

module hvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  hvt_pkg::sts_t sts,
	output hvt_pkg::cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_HASH1    = 9'b000000010,
		S_HASH2    = 9'b000000100,
		S_ADDR     = 9'b000001000,
		S_CMP      = 9'b000010000,
		S_SCAN_RD  = 9'b000100000,
		S_SCAN_CMP = 9'b001000000,
		S_RESULT   = 9'b010000000,
		S_CLEAR    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic phase_q, phase_d;
	hvt_pkg::status_t st_q, st_d;
	logic add_item;

	assign add_item = sts.kind == hvt_pkg::K_ADD_VOTER || sts.kind == hvt_pkg::K_ADD_CAND;
	assign s_tready = state_q == S_IDLE;

	always_comb begin
		cmd = '0;
		cmd.tsel = (sts.kind == hvt_pkg::K_ADD_CAND) || phase_q;
		cmd.use_choice = phase_q;
		cmd.status = st_q;
		state_d = state_q;
		phase_d = phase_q;
		st_d = st_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					phase_d = 1'b0;
					st_d = hvt_pkg::ST_OK;
					state_d = S_HASH1;
				end
			end
			S_HASH1: begin
				cmd.hash_a = 1'b1;
				state_d = (sts.kind == hvt_pkg::K_REPORT) ? S_SCAN_RD : S_HASH2;
			end
			S_HASH2: begin
				cmd.hash_b = 1'b1;
				state_d = S_ADDR;
			end
			S_ADDR: state_d = S_CMP;
			S_CMP: begin
				if (add_item) begin
					// Insert at the first empty slot, stop on the same key
					if (!sts.used) begin
						cmd.ins_wr = 1'b1;
						st_d = hvt_pkg::ST_OK;
						state_d = S_RESULT;
					end else if (sts.match) begin
						st_d = hvt_pkg::ST_OK;
						state_d = S_RESULT;
					end else if (sts.last) begin
						st_d = hvt_pkg::ST_FULL;
						state_d = S_RESULT;
					end else begin
						cmd.step = 1'b1;
						state_d = S_ADDR;
					end
				end else if (!phase_q) begin
					// Voter lookup
					if (sts.match) begin
						if (sts.voted) begin
							st_d = hvt_pkg::ST_ALREADY_VOTED;
							state_d = S_RESULT;
						end else begin
							cmd.vslot_ld = 1'b1;
							phase_d = 1'b1;
							state_d = S_HASH1;
						end
					end else if (!sts.used || sts.last) begin
						st_d = hvt_pkg::ST_VOTER_UNKNOWN;
						state_d = S_RESULT;
					end else begin
						cmd.step = 1'b1;
						state_d = S_ADDR;
					end
				end else begin
					// Candidate lookup, then count the vote
					if (sts.match) begin
						cmd.vote_wr = 1'b1;
						st_d = hvt_pkg::ST_OK;
						state_d = S_RESULT;
					end else if (!sts.used || sts.last) begin
						st_d = hvt_pkg::ST_CAND_UNKNOWN;
						state_d = S_RESULT;
					end else begin
						cmd.step = 1'b1;
						state_d = S_ADDR;
					end
				end
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d = sts.scan_last ? S_RESULT : S_SCAN_RD;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d = (sts.kind == hvt_pkg::K_REPORT) ? S_CLEAR : S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= 1'b0;
			st_q <= hvt_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			st_q <= st_d;
		end
	end

endmodule

FILE: sv/hashed_vote_tally.sv
// Top level of the hashed vote tally: controller plus datapath.
`timescale 1ns / 1ps

// Voter and candidate registry with vote counting.
// Input channel s_*: one transfer is one item; s_tuser holds the kind (add voter,
// add candidate, vote, report). Output channel m_*: exactly one result transfer
// per item, carrying a status and, on report, the winning candidate and its count.
// Config port: cfg_we writes cfg_data into register cfg_index (0 voter slots in
// use, 1 candidate slots in use); write only while the block is idle.
// Items are handled one at a time. An add runs two hash states, then an address
// and a compare state per table probe (the probe count depends on collisions, at
// most the slot count), and then loads the result register once it is free.
// A vote hashes and probes both tables, so it runs the hash states twice.
// A report scans every candidate table slot with a read and a compare state and
// loads its result; it then clears both tables, one slot per cycle over
// max(VOTER_SLOTS, CANDIDATE_SLOTS) slots, before the next item is taken.
// After an add or a vote, s_tready rises the cycle after its result is loaded.
// After reset the same clearing pass runs before s_tready first rises.
// A result waits in the output register while m_tready is low; the next item is
// still accepted and processed, and its result is held back until the register
// frees up.
module hashed_vote_tally #(
	parameter int VOTER_SLOTS = 1024,
	parameter int CANDIDATE_SLOTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [10:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// key_value[63:0], key_modulus[127:64], choice_value[191:128], choice_modulus[255:192]
	input  logic [255:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], winner_value[66:3], winner_modulus[130:67], winner_votes[141:131], zero
	output logic [143:0] m_tdata
);

	hvt_pkg::cmd_t cmd;
	hvt_pkg::sts_t sts;

	hvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hvt_datapath #(
		.VOTER_SLOTS     (VOTER_SLOTS),
		.CANDIDATE_SLOTS (CANDIDATE_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: sv/hvt_checker.sv
// Port-level checks of the hashed vote tally and their binding.
`timescale 1ns / 1ps

module hvt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	// Status code in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd4)
		else $error("bad status code");

	// Refusals carry no winner
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != 3'd0 |-> m_tdata[141:3] == '0)
		else $error("winner fields set on a refused item");

endmodule

bind hashed_vote_tally hvt_checker u_hvt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: verif/hashed_vote_tally_tb.sv
// Self-checking testbench for the hashed vote tally: random and directed items with a tally predictor.
`timescale 1ns / 1ps

module hashed_vote_tally_tb;

	localparam int VSLOTS = 1024;
	localparam int CSLOTS = 64;
	localparam int SETTLE = 1200;
	localparam int CYCLE_LIMIT = 20000000;

	typedef struct {
		hvt_pkg::kind_t kind;
		logic [63:0]    kv;
		logic [63:0]    kn;
		logic [63:0]    cv;
		logic [63:0]    cn;
	} ballot_t;

	typedef struct {
		hvt_pkg::status_t status;
		logic [63:0]      wv;
		logic [63:0]      wn;
		logic [10:0]      wc;
	} tally_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [10:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [255:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [143:0] m_tdata;

	hashed_vote_tally dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
		.m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Shadow tables and registers
	logic [63:0] voter_val [VSLOTS];
	logic [63:0] voter_mod [VSLOTS];
	bit voter_taken [VSLOTS];
	bit voter_voted [VSLOTS];
	logic [63:0] cand_val [CSLOTS];
	logic [63:0] cand_mod [CSLOTS];
	bit cand_taken [CSLOTS];
	int cand_count [CSLOTS];
	int voter_reg;
	int cand_reg;

	ballot_t ballot_q[$];
	tally_t tally_q[$];
	int mismatches;
	int cycles;
	bit took;
	int burst_left;
	int gap_left;
	int stall_mode;
	int stall_timer;

	function automatic int slots_in_use(int raw, int top);
		if (raw < 1) return 1;
		if (raw > top) return top;
		return raw;
	endfunction

	function automatic int probe_at(logic [63:0] v, int m, int i);
		logic [63:0] prod;
		logic [63:0] home;
		prod = 64'(v[31:0]) * 64'(hvt_pkg::GOLDEN_FRAC);
		home = (64'(prod[31:0]) * 64'(m)) >> 32;
		return int'((home + 64'(i / 2) + 64'((i * i) / 2)) % 64'(m));
	endfunction

	// Return the slot holding the key, or -1 at an empty slot or after m probes
	function automatic int find_key(bit cand, logic [63:0] v, logic [63:0] n);
		int m;
		int p;
		m = cand ? slots_in_use(cand_reg, CSLOTS) : slots_in_use(voter_reg, VSLOTS);
		for (int i = 0; i < m; i++) begin
			p = probe_at(v, m, i);
			if (cand ? !cand_taken[p] : !voter_taken[p]) return -1;
			if (cand ? (cand_val[p] == v && cand_mod[p] == n)
				: (voter_val[p] == v && voter_mod[p] == n)) return p;
		end
		return -1;
	endfunction

	function automatic hvt_pkg::status_t add_key(bit cand, logic [63:0] v, logic [63:0] n);
		int m;
		int p;
		m = cand ? slots_in_use(cand_reg, CSLOTS) : slots_in_use(voter_reg, VSLOTS);
		for (int i = 0; i < m; i++) begin
			p = probe_at(v, m, i);
			if (cand ? !cand_taken[p] : !voter_taken[p]) begin
				if (cand) begin
					cand_taken[p] = 1; cand_val[p] = v; cand_mod[p] = n;
				end else begin
					voter_taken[p] = 1; voter_val[p] = v; voter_mod[p] = n;
				end
				return hvt_pkg::ST_OK;
			end
			if (cand ? (cand_val[p] == v && cand_mod[p] == n)
				: (voter_val[p] == v && voter_mod[p] == n)) return hvt_pkg::ST_OK;
		end
		return hvt_pkg::ST_FULL;
	endfunction

	function automatic void wipe_tables();
		for (int s = 0; s < VSLOTS; s++) begin
			voter_taken[s] = 0; voter_voted[s] = 0;
		end
		for (int s = 0; s < CSLOTS; s++) begin
			cand_taken[s] = 0; cand_count[s] = 0;
		end
	endfunction

	// Apply one item to the shadow tables and return its expected result
	function automatic tally_t tally_item(ballot_t b);
		tally_t r;
		int pv;
		int pc;
		int best;
		r.status = hvt_pkg::ST_OK; r.wv = '0; r.wn = '0; r.wc = '0;
		case (b.kind)
			hvt_pkg::K_ADD_VOTER: r.status = add_key(0, b.kv, b.kn);
			hvt_pkg::K_ADD_CAND: r.status = add_key(1, b.kv, b.kn);
			hvt_pkg::K_VOTE: begin
				pv = find_key(0, b.kv, b.kn);
				if (pv < 0) r.status = hvt_pkg::ST_VOTER_UNKNOWN;
				else if (voter_voted[pv]) r.status = hvt_pkg::ST_ALREADY_VOTED;
				else begin
					pc = find_key(1, b.cv, b.cn);
					if (pc < 0) r.status = hvt_pkg::ST_CAND_UNKNOWN;
					else begin
						voter_voted[pv] = 1;
						if (cand_count[pc] < 2047) cand_count[pc]++;
					end
				end
			end
			default: begin
				best = 0;
				for (int s = 0; s < CSLOTS; s++) begin
					if (cand_taken[s] && cand_count[s] > best) begin
						best = cand_count[s]; r.wv = cand_val[s]; r.wn = cand_mod[s];
					end
				end
				r.wc = 11'(best);
				wipe_tables();
			end
		endcase
		return r;
	endfunction

	// Clock
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Monitor: predict on input transfers, check output transfers
	always @(posedge clk) begin
		tally_t want;
		tally_t got;
		ballot_t b;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				b.kind = hvt_pkg::kind_t'(s_tuser);
				b.kv = s_tdata[63:0]; b.kn = s_tdata[127:64];
				b.cv = s_tdata[191:128]; b.cn = s_tdata[255:192];
				tally_q.push_back(tally_item(b));
				took = 1;
			end
			if (m_tvalid && m_tready) begin
				got.status = hvt_pkg::status_t'(m_tdata[2:0]);
				got.wv = m_tdata[66:3]; got.wn = m_tdata[130:67]; got.wc = m_tdata[141:131];
				if (tally_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result transfer %h", m_tdata);
				end else begin
					want = tally_q.pop_front();
					if (got.status !== want.status || got.wv !== want.wv
						|| got.wn !== want.wn || got.wc !== want.wc
						|| m_tdata[143:142] !== 2'b00) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp st=%0d wv=%h wn=%h wc=%0d, got st=%0d wv=%h wn=%h wc=%0d",
								want.status, want.wv, want.wn, want.wc,
								got.status, got.wv, got.wn, got.wc);
					end
				end
			end
		end
	end

	// Driver: bursts with gaps on the input side
	always @(negedge clk) begin
		ballot_t b;
		if (arst_n) begin
			if (!s_tvalid || took) begin
				took = 0;
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (ballot_q.size() > 0) begin
					b = ballot_q.pop_front();
					s_tdata <= {b.cn, b.cv, b.kn, b.kv};
					s_tuser <= b.kind;
					s_tvalid <= 1'b1;
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern that switches mode each time a random timer runs out
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_timer == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_timer = $urandom_range(50, 400);
			end else stall_timer--;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (cycles % 7) < 4;
			endcase
		end
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_item(hvt_pkg::kind_t k, logic [63:0] kv, logic [63:0] kn,
			logic [63:0] cv = '0, logic [63:0] cn = '0);
		ballot_t b;
		b.kind = k; b.kv = kv; b.kn = kn; b.cv = cv; b.cn = cn;
		ballot_q.push_back(b);
	endtask

	// Hold until every item has been taken and answered, then let the clearing pass finish
	task automatic drain();
		while (ballot_q.size() > 0 || s_tvalid || tally_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= 11'(value);
		if (idx == hvt_pkg::REG_VOTER_SLOTS) voter_reg = value & 'h7FF;
		else cand_reg = value & 'h7F;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_slots(int top);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return top;
			3: return 2047;
			4: return $urandom_range(2, 16);
			default: return $urandom_range(1, top);
		endcase
	endfunction

	initial begin
		logic [63:0] vk [$];
		logic [63:0] vm [$];
		logic [63:0] ck [$];
		logic [63:0] cm [$];
		logic [63:0] x;
		int issued;
		int nv;
		int nc;
		int j;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
		mismatches = 0; cycles = 0; took = 0;
		burst_left = 0; gap_left = 0; stall_mode = 0; stall_timer = 0;
		voter_reg = 1024; cand_reg = 64;
		wipe_tables();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (SETTLE) @(posedge clk);

		// Directed: tiny tables, full tables, duplicates, each vote refusal, reports
		write_reg(hvt_pkg::REG_VOTER_SLOTS, 2);
		write_reg(hvt_pkg::REG_CAND_SLOTS, 1);
		queue_item(hvt_pkg::K_ADD_CAND, '1, '1);
		queue_item(hvt_pkg::K_ADD_CAND, '0, '0);
		queue_item(hvt_pkg::K_ADD_VOTER, '1, '1);
		queue_item(hvt_pkg::K_ADD_VOTER, '0, '0);
		queue_item(hvt_pkg::K_ADD_VOTER, 64'h5, 64'h7);
		queue_item(hvt_pkg::K_ADD_VOTER, '1, '1);
		queue_item(hvt_pkg::K_VOTE, 64'h5, 64'h7, '1, '1);
		queue_item(hvt_pkg::K_VOTE, '0, '0, '0, '0);
		queue_item(hvt_pkg::K_VOTE, '0, '0, '1, '1);
		queue_item(hvt_pkg::K_VOTE, '0, '0, '1, '1);
		queue_item(hvt_pkg::K_VOTE, '1, '1, '1, '1);
		queue_item(hvt_pkg::K_REPORT, '1, '1, '1, '1);
		queue_item(hvt_pkg::K_REPORT, '0, '0);
		drain();
		// Same low word, different upper bits: forced collisions with full-size tables
		write_reg(hvt_pkg::REG_VOTER_SLOTS, 1024);
		write_reg(hvt_pkg::REG_CAND_SLOTS, 64);
		queue_item(hvt_pkg::K_ADD_CAND, 64'h1_DEADBEEF, 64'h3);
		queue_item(hvt_pkg::K_ADD_CAND, 64'h2_DEADBEEF, 64'h3);
		queue_item(hvt_pkg::K_ADD_VOTER, 64'h1_DEADBEEF, 64'h9);
		queue_item(hvt_pkg::K_ADD_VOTER, 64'h1_DEADBEEF, 64'hA);
		queue_item(hvt_pkg::K_VOTE, 64'h1_DEADBEEF, 64'hA, 64'h2_DEADBEEF, 64'h3);
		queue_item(hvt_pkg::K_VOTE, 64'h1_DEADBEEF, 64'h9, 64'h2_DEADBEEF, 64'h3);
		queue_item(hvt_pkg::K_VOTE, 64'h1_DEADBEEF, 64'hB, 64'h2_DEADBEEF, 64'h3);
		queue_item(hvt_pkg::K_REPORT, '0, '0);
		drain();
		issued = 21;

		// Random elections with random table sizes
		while (issued < 700) begin
			write_reg(hvt_pkg::REG_VOTER_SLOTS, pick_slots(VSLOTS));
			write_reg(hvt_pkg::REG_CAND_SLOTS, pick_slots(CSLOTS));
			vk.delete(); vm.delete(); ck.delete(); cm.delete();
			nv = $urandom_range(1, 30);
			nc = $urandom_range(1, 8);
			for (int i = 0; i < nc; i++) begin
				x = rand_word();
				if (i > 0 && $urandom_range(0, 3) == 0) x[31:0] = ck[0][31:0];
				ck.push_back(x); cm.push_back(rand_word());
				queue_item(hvt_pkg::K_ADD_CAND, ck[i], cm[i]);
			end
			for (int i = 0; i < nv; i++) begin
				x = rand_word();
				if (i > 0 && $urandom_range(0, 3) == 0) x[31:0] = vk[i-1][31:0];
				vk.push_back(x);
				vm.push_back(($urandom_range(0, 4) == 0 && i > 0) ? vm[0] : rand_word());
				queue_item(hvt_pkg::K_ADD_VOTER, vk[i], vm[i]);
				if ($urandom_range(0, 7) == 0) queue_item(hvt_pkg::K_ADD_VOTER, vk[i], vm[i]);
			end
			for (int i = 0; i < nv + 4; i++) begin
				j = $urandom_range(0, nv - 1);
				case ($urandom_range(0, 9))
					0: queue_item(hvt_pkg::K_VOTE, rand_word(), rand_word(), ck[0], cm[0]);
					1: queue_item(hvt_pkg::K_VOTE, vk[j], vm[j], rand_word(), rand_word());
					2: queue_item(hvt_pkg::kind_t'($urandom_range(0, 2)), rand_word(),
						rand_word(), rand_word(), rand_word());
					default: begin
						nc = $urandom_range(0, ck.size() - 1);
						queue_item(hvt_pkg::K_VOTE, vk[j], vm[j], ck[nc], cm[nc]);
					end
				endcase
			end
			queue_item(hvt_pkg::K_REPORT, rand_word(), rand_word(), rand_word(), rand_word());
			issued += ck.size() + 2 * nv + 5;
			drain();
		end

		if (tally_q.size() == 0 && mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/hvt_pkg.sv
sv/hvt_datapath.sv
sv/hvt_ctrl.sv
sv/hashed_vote_tally.sv
sv/hvt_checker.sv
verif/hashed_vote_tally_tb.sv
